### rtl/fgn_pkg.sv
// ----------------------------------------------------------------------------
// fgn_pkg: shared definitions for the fractal gradient noise block
// Sizes, fixed-point constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package fgn_pkg;

    localparam int TABLE_DEPTH = 16384;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 16;

    localparam int MAP_BITS    = 13;
    localparam int CELL_BITS   = 7;
    localparam int MAX_OCTAVES = 8;
    localparam int OCT_BITS    = $clog2(MAX_OCTAVES);
    localparam int LAT_BITS    = CELL_BITS + MAX_OCTAVES - 1;
    localparam int DIV_BITS    = COORD_BITS + LAT_BITS + FRAC_BITS;
    localparam int QCELL_BITS  = DIV_BITS - FRAC_BITS;
    localparam int DCNT_BITS   = $clog2(DIV_BITS + 1);

    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;
    localparam int SUM_W  = 56;
    localparam int GRAD_Q = 14;
    localparam int WGT_Q  = 14;

    // 2^30 / sqrt(2), split so each partial product stays narrow.
    localparam longint SQRT_HALF_Q30 = 759250125;
    localparam int     C_SPLIT       = 16;
    localparam int     C_HI          = int'(SQRT_HALF_Q30 >> C_SPLIT);
    localparam int     C_LO          = int'(SQRT_HALF_Q30 % (64'd1 << C_SPLIT));

    typedef enum logic [2:0] {
        REG_MAP_WIDTH    = 3'd0,
        REG_MAP_HEIGHT   = 3'd1,
        REG_CELLS_X      = 3'd2,
        REG_CELLS_Y      = 3'd3,
        REG_OCTAVE_COUNT = 3'd4,
        REG_WRAP_MODE    = 3'd5,
        REG_OCTAVE_DECAY = 3'd6,
        REG_NORM_RECIP   = 3'd7
    } reg_index_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_POSMUL = 8'b0000_0010,
        ST_DIVLD  = 8'b0000_0100,
        ST_DIV    = 8'b0000_1000,
        ST_WRAP   = 8'b0001_0000,
        ST_MATH   = 8'b0010_0000,
        ST_FIN    = 8'b0100_0000,
        ST_FIN2   = 8'b1000_0000
    } state_t;

endpackage

### rtl/fractal_gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d: fractal 2-D gradient noise evaluator
// Gradient table, octave sequencer, shared multiplier and serial divider.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid/in_ready) carries two kinds of
// transaction. With func low, one gradient (grad_x, grad_y) is written to the
// table entry table_index and nothing is returned. With func high, noise is
// evaluated at (pos_x, pos_y) and one noise_value transaction leaves on the
// output channel (out_valid/out_ready). Every table entry that a sample
// touches must have been loaded first.
// A sample runs octave by octave. Each octave runs two serial divisions of
// DIV_BITS (42) quotient bits, one per axis, and then the multiplier steps.
// The divider yields one quotient bit per cycle, and a single shared 32x32
// multiplier serves every step. in_ready is high only while the sequencer
// is idle.
// The result sits in an output register; a stalled receiver holds it there
// while a new transaction is already accepted, and only the next result waits
// for the register to drain. Reset returns the sequencer to idle, drops any
// pending result and loads the register defaults; table contents are kept
// and are undefined until loaded. Configuration is written over the APB port.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_2d (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [13:0] table_index,
    input  logic signed [15:0] grad_x,
    input  logic signed [15:0] grad_y,
    input  logic [fgn_pkg::COORD_BITS-1:0] pos_x,
    input  logic [fgn_pkg::COORD_BITS-1:0] pos_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] noise_value
);

    localparam int F  = fgn_pkg::FRAC_BITS;
    localparam int AW = fgn_pkg::ADDR_BITS;
    localparam int MW = fgn_pkg::MUL_W;
    localparam int PW = fgn_pkg::PROD_W;
    localparam logic signed [MW-1:0] ONE  = MW'(64'sd1 <<< F);
    localparam logic signed [MW-1:0] HALF = MW'(64'sd1 <<< (F - 1));
    localparam logic signed [MW-1:0] S_MAX = MW'(64'sh7FFF_FFFF);

    // Configuration registers.
    logic [fgn_pkg::MAP_BITS-1:0]  map_width_reg, map_height_reg;
    logic [fgn_pkg::CELL_BITS-1:0] cells_x_reg, cells_y_reg;
    logic [3:0]  octave_count_reg;
    logic [1:0]  wrap_mode_reg;
    logic [15:0] octave_decay_reg, norm_recip_reg;

    fgn_pkg::reg_index_t cfg_idx;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = fgn_pkg::reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= 13'd256;
            map_height_reg   <= 13'd256;
            cells_x_reg      <= 7'd4;
            cells_y_reg      <= 7'd4;
            octave_count_reg <= 4'd4;
            wrap_mode_reg    <= 2'd1;
            octave_decay_reg <= 16'd8192;
            norm_recip_reg   <= 16'd8738;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                fgn_pkg::REG_MAP_WIDTH:    map_width_reg    <= pwdata[12:0];
                fgn_pkg::REG_MAP_HEIGHT:   map_height_reg   <= pwdata[12:0];
                fgn_pkg::REG_CELLS_X:      cells_x_reg      <= pwdata[6:0];
                fgn_pkg::REG_CELLS_Y:      cells_y_reg      <= pwdata[6:0];
                fgn_pkg::REG_OCTAVE_COUNT: octave_count_reg <= pwdata[3:0];
                fgn_pkg::REG_WRAP_MODE:    wrap_mode_reg    <= pwdata[1:0];
                fgn_pkg::REG_OCTAVE_DECAY: octave_decay_reg <= pwdata[15:0];
                fgn_pkg::REG_NORM_RECIP:   norm_recip_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            fgn_pkg::REG_MAP_WIDTH:    prdata = 32'(map_width_reg);
            fgn_pkg::REG_MAP_HEIGHT:   prdata = 32'(map_height_reg);
            fgn_pkg::REG_CELLS_X:      prdata = 32'(cells_x_reg);
            fgn_pkg::REG_CELLS_Y:      prdata = 32'(cells_y_reg);
            fgn_pkg::REG_OCTAVE_COUNT: prdata = 32'(octave_count_reg);
            fgn_pkg::REG_WRAP_MODE:    prdata = 32'(wrap_mode_reg);
            fgn_pkg::REG_OCTAVE_DECAY: prdata = 32'(octave_decay_reg);
            fgn_pkg::REG_NORM_RECIP:   prdata = 32'(norm_recip_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    // Sequencer and datapath registers.
    fgn_pkg::state_t state_reg, state_next;
    logic [fgn_pkg::OCT_BITS-1:0] oct_reg;
    logic [3:0]  octs_reg;
    logic        axis_reg;
    logic [4:0]  step_reg;
    logic [fgn_pkg::DCNT_BITS-1:0] div_cnt_reg;
    logic        out_valid_reg;
    logic [15:0] noise_value_reg;

    logic [fgn_pkg::COORD_BITS-1:0] pos_x_reg, pos_y_reg;
    logic [fgn_pkg::DIV_BITS-1:0]   div_num_reg;
    logic [fgn_pkg::MAP_BITS-1:0]   div_rem_reg;
    logic [fgn_pkg::QCELL_BITS-1:0] cx_reg, cy_reg;
    logic [F-1:0]  tx_reg, ty_reg;
    logic [AW-1:0] vx0_reg, vx1_reg, vy0_reg, vy1_reg, ky0_reg, ky1_reg;
    logic [31:0]   rd_reg;
    logic signed [PW-1:0] acc_reg, prod_reg;
    logic signed [MW-1:0] dot0_reg, dot1_reg, dot2_reg, dot3_reg;
    logic signed [MW-1:0] t3_reg, sx_reg, sy_reg, top_reg, n_reg, w_reg;
    logic signed [fgn_pkg::SUM_W-1:0] sum_reg;

    logic [31:0] table_mem [fgn_pkg::TABLE_DEPTH];

    // Shared multiplier controls and table read port.
    logic                 mul_en, rd_en;
    logic signed [MW-1:0] mul_a, mul_b;
    logic [AW-1:0]        rd_addr;

    logic accept_in, load_ok, last_oct;
    logic [fgn_pkg::LAT_BITS-1:0] nx, ny;
    logic [fgn_pkg::MAP_BITS-1:0] div_d;
    logic [fgn_pkg::MAP_BITS:0]   rem_try;
    logic                         rem_ge;
    logic [fgn_pkg::MAP_BITS-1:0] rem_new;
    logic [fgn_pkg::DIV_BITS-1:0] num_new;
    logic [fgn_pkg::QCELL_BITS:0] vx0_f, vx1_f, vy0_f, vy1_f;
    logic signed [PW-1:0] prod_sh, dot_c, v_full, s_sh, res_sh;
    logic signed [MW-1:0] tx_s, ty_s, gx_s, gy_s, bot_c, n_c, v_c, s_clamp;

    assign in_ready    = (state_reg == fgn_pkg::ST_IDLE);
    assign accept_in   = in_valid && in_ready;
    assign load_ok     = 32'(table_index) < fgn_pkg::TABLE_DEPTH;
    assign out_valid   = out_valid_reg;
    assign noise_value = noise_value_reg;
    assign last_oct    = ({1'b0, oct_reg} + 4'd1) >= octs_reg;

    assign nx = fgn_pkg::LAT_BITS'(cells_x_reg) << oct_reg;
    assign ny = fgn_pkg::LAT_BITS'(cells_y_reg) << oct_reg;

    // One restoring division step per cycle; a zero map extent acts as one.
    always_comb
    begin
        div_d = axis_reg ? map_height_reg : map_width_reg;
        if (div_d == '0)
        begin
            div_d = fgn_pkg::MAP_BITS'(1);
        end
    end
    assign rem_try = {div_rem_reg, div_num_reg[fgn_pkg::DIV_BITS-1]};
    assign rem_ge  = rem_try >= {1'b0, div_d};
    assign rem_new = rem_ge ? fgn_pkg::MAP_BITS'(rem_try - {1'b0, div_d})
                            : fgn_pkg::MAP_BITS'(rem_try);
    assign num_new = {div_num_reg[fgn_pkg::DIV_BITS-2:0], rem_ge};

    // Corner indices, with one lattice width taken off where the axis wraps.
    always_comb
    begin
        vx0_f = {1'b0, cx_reg};
        vx1_f = {1'b0, cx_reg} + 1'b1;
        vy0_f = {1'b0, cy_reg};
        vy1_f = {1'b0, cy_reg} + 1'b1;
        if (wrap_mode_reg[0] && vx0_f >= (fgn_pkg::QCELL_BITS + 1)'(nx))
        begin
            vx0_f = vx0_f - (fgn_pkg::QCELL_BITS + 1)'(nx);
        end
        if (wrap_mode_reg[0] && vx1_f >= (fgn_pkg::QCELL_BITS + 1)'(nx))
        begin
            vx1_f = vx1_f - (fgn_pkg::QCELL_BITS + 1)'(nx);
        end
        if (wrap_mode_reg[1] && vy0_f >= (fgn_pkg::QCELL_BITS + 1)'(ny))
        begin
            vy0_f = vy0_f - (fgn_pkg::QCELL_BITS + 1)'(ny);
        end
        if (wrap_mode_reg[1] && vy1_f >= (fgn_pkg::QCELL_BITS + 1)'(ny))
        begin
            vy1_f = vy1_f - (fgn_pkg::QCELL_BITS + 1)'(ny);
        end
    end

    assign tx_s    = signed'(MW'(tx_reg));
    assign ty_s    = signed'(MW'(ty_reg));
    assign gx_s    = MW'(signed'(rd_reg[31:16]));
    assign gy_s    = MW'(signed'(rd_reg[15:0]));
    assign prod_sh = prod_reg >>> F;
    assign dot_c   = (acc_reg + prod_reg) >>> fgn_pkg::GRAD_Q;
    assign bot_c   = dot2_reg + MW'(prod_sh);
    assign n_c     = top_reg + MW'(prod_sh);
    assign v_full  = ((prod_reg <<< fgn_pkg::C_SPLIT) + acc_reg) >>> 30;
    assign v_c     = MW'(v_full) + HALF;
    assign s_sh    = PW'(sum_reg >>> fgn_pkg::WGT_Q);
    assign res_sh  = prod_reg >>> (F - 2);

    always_comb
    begin
        if (s_sh < 0)
        begin
            s_clamp = '0;
        end
        else if (s_sh > PW'(S_MAX))
        begin
            s_clamp = S_MAX;
        end
        else
        begin
            s_clamp = MW'(s_sh);
        end
    end

    // Operand selection for the shared multiplier, one step at a time.
    always_comb
    begin
        mul_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            fgn_pkg::ST_POSMUL:
            begin
                mul_en = 1'b1;
                mul_a  = axis_reg ? MW'(pos_y_reg) : MW'(pos_x_reg);
                mul_b  = axis_reg ? MW'(ny) : MW'(nx);
            end
            fgn_pkg::ST_MATH:
            begin
                mul_en = 1'b1;
                case (step_reg)
                    5'd0:
                    begin
                        mul_a = MW'(vy0_reg);
                        mul_b = MW'(nx);
                    end
                    5'd1:
                    begin
                        mul_a = MW'(vy1_reg);
                        mul_b = MW'(nx);
                    end
                    5'd2:
                    begin
                        mul_en  = 1'b0;
                        rd_en   = 1'b1;
                        rd_addr = vx0_reg + ky0_reg;
                    end
                    5'd3:
                    begin
                        mul_a = gx_s;
                        mul_b = tx_s;
                    end
                    5'd4:
                    begin
                        mul_a = gy_s;
                        mul_b = ty_s;
                    end
                    5'd5:
                    begin
                        mul_en  = 1'b0;
                        rd_en   = 1'b1;
                        rd_addr = vx1_reg + ky0_reg;
                    end
                    5'd6:
                    begin
                        mul_a = gx_s;
                        mul_b = tx_s - ONE;
                    end
                    5'd7:
                    begin
                        mul_a = gy_s;
                        mul_b = ty_s;
                    end
                    5'd8:
                    begin
                        mul_en  = 1'b0;
                        rd_en   = 1'b1;
                        rd_addr = vx0_reg + ky1_reg;
                    end
                    5'd9:
                    begin
                        mul_a = gx_s;
                        mul_b = tx_s;
                    end
                    5'd10:
                    begin
                        mul_a = gy_s;
                        mul_b = ty_s - ONE;
                    end
                    5'd11:
                    begin
                        mul_en  = 1'b0;
                        rd_en   = 1'b1;
                        rd_addr = vx1_reg + ky1_reg;
                    end
                    5'd12:
                    begin
                        mul_a = gx_s;
                        mul_b = tx_s - ONE;
                    end
                    5'd13:
                    begin
                        mul_a = gy_s;
                        mul_b = ty_s - ONE;
                    end
                    // Quintic fade of the x fraction, Horner form.
                    5'd14:
                    begin
                        mul_a = tx_s;
                        mul_b = tx_s;
                    end
                    5'd15:
                    begin
                        mul_a = MW'(prod_sh);
                        mul_b = tx_s;
                    end
                    5'd16:
                    begin
                        mul_a = 6 * tx_s - 15 * ONE;
                        mul_b = tx_s;
                    end
                    5'd17:
                    begin
                        mul_a = t3_reg;
                        mul_b = MW'(prod_sh) + 10 * ONE;
                    end
                    // The same for the y fraction.
                    5'd18:
                    begin
                        mul_a = ty_s;
                        mul_b = ty_s;
                    end
                    5'd19:
                    begin
                        mul_a = MW'(prod_sh);
                        mul_b = ty_s;
                    end
                    5'd20:
                    begin
                        mul_a = 6 * ty_s - 15 * ONE;
                        mul_b = ty_s;
                    end
                    5'd21:
                    begin
                        mul_a = t3_reg;
                        mul_b = MW'(prod_sh) + 10 * ONE;
                    end
                    5'd22:
                    begin
                        mul_a = dot1_reg - dot0_reg;
                        mul_b = sx_reg;
                    end
                    5'd23:
                    begin
                        mul_a = dot3_reg - dot2_reg;
                        mul_b = sx_reg;
                    end
                    5'd24:
                    begin
                        mul_a = bot_c - top_reg;
                        mul_b = sy_reg;
                    end
                    5'd25:
                    begin
                        mul_a = n_c;
                        mul_b = MW'(fgn_pkg::C_LO);
                    end
                    5'd26:
                    begin
                        mul_a = n_reg;
                        mul_b = MW'(fgn_pkg::C_HI);
                    end
                    5'd27:
                    begin
                        mul_a = v_c;
                        mul_b = w_reg;
                    end
                    5'd28:
                    begin
                        mul_a = w_reg;
                        mul_b = MW'(octave_decay_reg);
                    end
                    default: mul_en = 1'b0;
                endcase
            end
            fgn_pkg::ST_FIN:
            begin
                mul_en = 1'b1;
                mul_a  = s_clamp;
                mul_b  = MW'(norm_recip_reg);
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fgn_pkg::ST_IDLE:
            begin
                if (accept_in && func)
                begin
                    state_next = (octave_count_reg == 4'd0) ? fgn_pkg::ST_FIN
                                                            : fgn_pkg::ST_POSMUL;
                end
            end
            fgn_pkg::ST_POSMUL: state_next = fgn_pkg::ST_DIVLD;
            fgn_pkg::ST_DIVLD:  state_next = fgn_pkg::ST_DIV;
            fgn_pkg::ST_DIV:
            begin
                if (div_cnt_reg == fgn_pkg::DCNT_BITS'(1))
                begin
                    state_next = axis_reg ? fgn_pkg::ST_WRAP : fgn_pkg::ST_POSMUL;
                end
            end
            fgn_pkg::ST_WRAP: state_next = fgn_pkg::ST_MATH;
            fgn_pkg::ST_MATH:
            begin
                if (step_reg == 5'd29)
                begin
                    state_next = last_oct ? fgn_pkg::ST_FIN : fgn_pkg::ST_POSMUL;
                end
            end
            fgn_pkg::ST_FIN: state_next = fgn_pkg::ST_FIN2;
            fgn_pkg::ST_FIN2:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = fgn_pkg::ST_IDLE;
                end
            end
            default: state_next = fgn_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fgn_pkg::ST_IDLE;
            oct_reg       <= '0;
            octs_reg      <= '0;
            axis_reg      <= 1'b0;
            step_reg      <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // A finished sample refills the output register as it drains.
            if (state_reg == fgn_pkg::ST_FIN2 && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                fgn_pkg::ST_IDLE:
                begin
                    oct_reg  <= '0;
                    axis_reg <= 1'b0;
                    octs_reg <= (octave_count_reg > 4'(fgn_pkg::MAX_OCTAVES))
                                ? 4'(fgn_pkg::MAX_OCTAVES) : octave_count_reg;
                end
                fgn_pkg::ST_DIVLD: div_cnt_reg <= fgn_pkg::DCNT_BITS'(fgn_pkg::DIV_BITS);
                fgn_pkg::ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == fgn_pkg::DCNT_BITS'(1))
                    begin
                        axis_reg <= !axis_reg;
                    end
                end
                fgn_pkg::ST_WRAP: step_reg <= '0;
                fgn_pkg::ST_MATH:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd29 && !last_oct)
                    begin
                        oct_reg <= oct_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        case (state_reg)
            fgn_pkg::ST_IDLE:
            begin
                pos_x_reg <= pos_x;
                pos_y_reg <= pos_y;
                sum_reg   <= '0;
                w_reg     <= MW'(1 << fgn_pkg::WGT_Q);
            end
            fgn_pkg::ST_DIVLD:
            begin
                div_num_reg <= {prod_reg[fgn_pkg::COORD_BITS+fgn_pkg::LAT_BITS-1:0],
                                F'(0)};
                div_rem_reg <= '0;
            end
            fgn_pkg::ST_DIV:
            begin
                div_num_reg <= num_new;
                div_rem_reg <= rem_new;
                if (div_cnt_reg == fgn_pkg::DCNT_BITS'(1))
                begin
                    if (axis_reg)
                    begin
                        cy_reg <= num_new[fgn_pkg::DIV_BITS-1:F];
                        ty_reg <= num_new[F-1:0];
                    end
                    else
                    begin
                        cx_reg <= num_new[fgn_pkg::DIV_BITS-1:F];
                        tx_reg <= num_new[F-1:0];
                    end
                end
            end
            fgn_pkg::ST_WRAP:
            begin
                vx0_reg <= vx0_f[AW-1:0];
                vx1_reg <= vx1_f[AW-1:0];
                vy0_reg <= vy0_f[AW-1:0];
                vy1_reg <= vy1_f[AW-1:0];
            end
            fgn_pkg::ST_MATH:
            begin
                case (step_reg)
                    5'd1:  ky0_reg  <= prod_reg[AW-1:0];
                    5'd2:  ky1_reg  <= prod_reg[AW-1:0];
                    5'd4:  acc_reg  <= prod_reg;
                    5'd5:  dot0_reg <= MW'(dot_c);
                    5'd7:  acc_reg  <= prod_reg;
                    5'd8:  dot1_reg <= MW'(dot_c);
                    5'd10: acc_reg  <= prod_reg;
                    5'd11: dot2_reg <= MW'(dot_c);
                    5'd13: acc_reg  <= prod_reg;
                    5'd14: dot3_reg <= MW'(dot_c);
                    5'd16: t3_reg   <= MW'(prod_sh);
                    5'd18: sx_reg   <= MW'(prod_sh);
                    5'd20: t3_reg   <= MW'(prod_sh);
                    5'd22: sy_reg   <= MW'(prod_sh);
                    5'd23: top_reg  <= dot0_reg + MW'(prod_sh);
                    5'd24: dot2_reg <= bot_c;
                    5'd25: n_reg    <= n_c;
                    5'd26: acc_reg  <= prod_reg;
                    5'd28: sum_reg  <= sum_reg + fgn_pkg::SUM_W'(prod_reg);
                    5'd29: w_reg    <= MW'(prod_reg >>> fgn_pkg::WGT_Q);
                    default: ;
                endcase
            end
            fgn_pkg::ST_FIN2:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    noise_value_reg <= (res_sh > PW'(65535)) ? 16'hFFFF
                                                             : res_sh[15:0];
                end
            end
            default: ;
        endcase
    end

    // Gradient table: loads write, the sequencer reads entries through one read port.
    always_ff @(posedge clk)
    begin
        if (accept_in && !func && load_ok)
        begin
            table_mem[table_index[AW-1:0]] <= {grad_x, grad_y};
        end
        if (rd_en)
        begin
            rd_reg <= table_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fgn_pkg::ST_FIN2))
        else $error("result appeared outside the finish step");
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && !func) |=> (state_reg == fgn_pkg::ST_IDLE))
        else $error("table load started a computation");
    a_octave_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fgn_pkg::ST_MATH) |-> ({1'b0, oct_reg} < octs_reg))
        else $error("octave counter ran past the octave count");
    a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fgn_pkg::ST_DIV) |-> (div_cnt_reg != '0))
        else $error("divider iterating with an empty count");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for fractal_gradient_noise_2d
// Loads gradients and samples noise through the valid/ready input channel,
// predicts every noise_value in a bit-exact model of the octave arithmetic
// and checks each output transaction in order. Configuration is rewritten
// over APB between phases, covering the register extremes.
// ----------------------------------------------------------------------------

// Ordered store of noise values that the block still owes us.
class noise_scoreboard;
    logic [15:0] owed_noise[$];
    int          errors;

    function void note_input(bit is_sample, logic [15:0] predicted);
        if (is_sample)
            owed_noise = {owed_noise, predicted};
    endfunction

    function void check_result(logic [15:0] got);
        logic [15:0] want;
        if (owed_noise.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected noise_value %0d with nothing owed", got);
        end
        else
        begin
            want = owed_noise.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("noise_value mismatch: expected %0d, actual %0d", want, got);
            end
        end
    endfunction

    function bit clean();
        return (errors == 0) && (owed_noise.size() == 0);
    endfunction
endclass

module tb_top;

    localparam bit FUNC_LOAD   = 1'b0;
    localparam bit FUNC_SAMPLE = 1'b1;

    // Quiet time allowed after the last result before touching the registers;
    // it is longer than a sample of eight octaves takes.
    localparam int DRAIN_CYCLES = 1100;
    localparam int TOTAL_ITEMS  = 1800;
    localparam int CALM_ITEMS   = 1550;
    localparam int HOLD_ITEMS   = 600;
    localparam int HOLD_CYCLES  = 3000;
    localparam longint CYCLE_LIMIT = 10000000;
    localparam longint SQRT_HALF = 759250125;
    localparam int FB = fgn_pkg::FRAC_BITS;
    localparam int DEPTH = fgn_pkg::TABLE_DEPTH;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [13:0] table_index;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic [fgn_pkg::COORD_BITS-1:0] pos_x;
    logic [fgn_pkg::COORD_BITS-1:0] pos_y;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] noise_value;

    fractal_gradient_noise_2d dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .table_index(table_index), .grad_x(grad_x), .grad_y(grad_y),
        .pos_x(pos_x), .pos_y(pos_y),
        .out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
    );

    noise_scoreboard sb = new();

    // Shadow copy of the configuration, updated as each APB write lands.
    logic [12:0] cfg_map_w, cfg_map_h;
    logic [6:0]  cfg_cells_x, cfg_cells_y;
    logic [3:0]  cfg_octaves;
    logic [1:0]  cfg_wrap;
    logic [15:0] cfg_decay, cfg_norm;

    // Shadow gradient table. The written flags keep every sample on entries that
    // have actually been loaded, since unloaded entries hold no defined value.
    logic signed [15:0] shadow_gx [DEPTH];
    logic signed [15:0] shadow_gy [DEPTH];
    bit                 written   [DEPTH];

    int     items_done;
    bit     calm;
    bit     hold_req;
    bit     hold_done;
    int     hold_cnt;
    int     stall_left;
    longint cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Runaway guard: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: fixed-point noise arithmetic, all shifts are floors.
    // ------------------------------------------------------------------------

    // Maps one coordinate onto a lattice of n cells spread over ext map units.
    function automatic void split_axis(input longint unsigned pos,
                                       input longint unsigned n,
                                       input longint unsigned ext,
                                       output longint unsigned cell_idx,
                                       output longint frac);
        longint unsigned p;
        longint unsigned e;
        e = (ext == 0) ? 1 : ext;
        p = pos * n;
        cell_idx = p / e;
        frac = longint'(((p % e) << FB) / e);
    endfunction

    // Table entry used by corner j (bit0 = right, bit1 = lower) at one octave.
    function automatic int corner_key(input logic [11:0] px, input logic [11:0] py,
                                      input int oct, input int j);
        longint unsigned nx, ny, cx, cy, vx, vy;
        longint tx, ty;
        nx = longint'(cfg_cells_x) << oct;
        ny = longint'(cfg_cells_y) << oct;
        split_axis(px, nx, cfg_map_w, cx, tx);
        split_axis(py, ny, cfg_map_h, cy, ty);
        vx = cx + (j & 1);
        vy = cy + (j >> 1);
        // Wrapping folds the far edge back once onto the first cell.
        if (cfg_wrap[0] && vx >= nx)
            vx = vx - nx;
        if (cfg_wrap[1] && vy >= ny)
            vy = vy - ny;
        return int'((vx + vy * nx) % DEPTH);
    endfunction

    // Quintic fade 6t^5 - 15t^4 + 10t^3 by Horner, each product floored.
    function automatic longint quintic_fade(input longint t);
        longint one, t2, t3, inner;
        one = longint'(1) << FB;
        t2 = (t * t) >>> FB;
        t3 = (t2 * t) >>> FB;
        inner = (((6 * t - 15 * one) * t) >>> FB) + 10 * one;
        return (t3 * inner) >>> FB;
    endfunction

    function automatic longint lerp_q(input longint a, input longint b, input longint s);
        return a + (((b - a) * s) >>> FB);
    endfunction

    function automatic longint octave_value(input logic [11:0] px, input logic [11:0] py,
                                            input int oct);
        longint unsigned nx, ny, cx, cy;
        longint tx, ty, dx, dy, sx, sy, top, bot, n;
        longint dots[4];
        longint one;
        int key;
        one = longint'(1) << FB;
        nx = longint'(cfg_cells_x) << oct;
        ny = longint'(cfg_cells_y) << oct;
        split_axis(px, nx, cfg_map_w, cx, tx);
        split_axis(py, ny, cfg_map_h, cy, ty);
        for (int j = 0; j < 4; j++)
        begin
            key = corner_key(px, py, oct, j);
            dx = tx - ((j & 1) ? one : 0);
            dy = ty - ((j >> 1) ? one : 0);
            dots[j] = (longint'(shadow_gx[key]) * dx + longint'(shadow_gy[key]) * dy)
                      >>> fgn_pkg::GRAD_Q;
        end
        sx = quintic_fade(tx);
        sy = quintic_fade(ty);
        top = lerp_q(dots[0], dots[1], sx);
        bot = lerp_q(dots[2], dots[3], sx);
        n = lerp_q(top, bot, sy);
        return ((n * SQRT_HALF) >>> 30) + (longint'(1) << (FB - 1));
    endfunction

    function automatic int active_octaves();
        return (cfg_octaves > fgn_pkg::MAX_OCTAVES) ? fgn_pkg::MAX_OCTAVES
                                                     : int'(cfg_octaves);
    endfunction

    function automatic logic [15:0] predict_noise(input logic [11:0] px,
                                                  input logic [11:0] py);
        longint weight, sum, res;
        weight = longint'(1) << fgn_pkg::WGT_Q;
        sum = 0;
        for (int o = 0; o < active_octaves(); o++)
        begin
            sum += octave_value(px, py, o) * weight;
            weight = (weight * longint'(cfg_decay)) >>> fgn_pkg::WGT_Q;
        end
        res = ((sum >>> fgn_pkg::WGT_Q) * longint'(cfg_norm)) >>> (FB - 2);
        if (res < 0)
            res = 0;
        if (res > 65535)
            res = 65535;
        return res[15:0];
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // APB write: setup cycle, then access cycle; the register lands at the
    // rising edge that closes the access cycle.
    task automatic write_reg(input fgn_pkg::reg_index_t r, input logic [31:0] v);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {r, 2'b00};
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        case (r)
            fgn_pkg::REG_MAP_WIDTH:    cfg_map_w = v[12:0];
            fgn_pkg::REG_MAP_HEIGHT:   cfg_map_h = v[12:0];
            fgn_pkg::REG_CELLS_X:      cfg_cells_x = v[6:0];
            fgn_pkg::REG_CELLS_Y:      cfg_cells_y = v[6:0];
            fgn_pkg::REG_OCTAVE_COUNT: cfg_octaves = v[3:0];
            fgn_pkg::REG_WRAP_MODE:    cfg_wrap = v[1:0];
            fgn_pkg::REG_OCTAVE_DECAY: cfg_decay = v[15:0];
            fgn_pkg::REG_NORM_RECIP:   cfg_norm = v[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_config(input int mw, input int mh, input int cx, input int cy,
                              input int oc, input int wr, input int dc, input int nr);
        write_reg(fgn_pkg::REG_MAP_WIDTH, mw);
        write_reg(fgn_pkg::REG_MAP_HEIGHT, mh);
        write_reg(fgn_pkg::REG_CELLS_X, cx);
        write_reg(fgn_pkg::REG_CELLS_Y, cy);
        write_reg(fgn_pkg::REG_OCTAVE_COUNT, oc);
        write_reg(fgn_pkg::REG_WRAP_MODE, wr);
        write_reg(fgn_pkg::REG_OCTAVE_DECAY, dc);
        write_reg(fgn_pkg::REG_NORM_RECIP, nr);
    endtask

    // Offers one input transaction, possibly after a short idle burst, and
    // updates the predictor at the edge where it is accepted.
    task automatic send_item(input bit fn, input logic [13:0] idx,
                             input logic signed [15:0] gx, input logic signed [15:0] gy,
                             input logic [11:0] px, input logic [11:0] py);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func = fn;
        table_index = idx;
        grad_x = gx;
        grad_y = gy;
        pos_x = px;
        pos_y = py;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (fn == FUNC_LOAD)
        begin
            shadow_gx[idx] = gx;
            shadow_gy[idx] = gy;
            written[idx] = 1'b1;
            sb.note_input(1'b0, 16'h0);
        end
        else
        begin
            sb.note_input(1'b1, predict_noise(px, py));
        end
        items_done++;
    endtask

    function automatic logic signed [15:0] rand_grad();
        case ($urandom_range(0, 7))
            0: return -16'sd16384;
            1: return 16'sd16384;
            2: return 16'sd0;
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [11:0] rand_pos(input logic [12:0] ext);
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'd4095;
            2: return (ext == 0 || ext > 4096) ? 12'd4095 : 12'(ext - 1);
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic send_load(input int idx);
        send_item(FUNC_LOAD, 14'(idx), rand_grad(), rand_grad(), 12'($urandom), 12'($urandom));
    endtask

    // A well-formed sample: first load any corner entry that is still empty,
    // then ask for the noise value.
    task automatic send_sample(input logic [11:0] px, input logic [11:0] py);
        int k;
        for (int o = 0; o < active_octaves(); o++)
            for (int j = 0; j < 4; j++)
            begin
                k = corner_key(px, py, o, j);
                if (!written[k])
                    send_load(k);
            end
        send_item(FUNC_SAMPLE, 14'($urandom), 16'($urandom), 16'($urandom), px, py);
    endtask

    // Waits until every owed result is back, then for the block to go quiet.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.owed_noise.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int budget);
        int start;
        int r;
        start = items_done;
        while (items_done - start < budget && items_done < TOTAL_ITEMS)
        begin
            if (!hold_done && items_done >= HOLD_ITEMS)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (items_done >= CALM_ITEMS)
                calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 15)
                send_load($urandom_range(0, DEPTH - 1));
            else if (r < 18)
                send_load(($urandom_range(0, 1) == 1) ? DEPTH - 1 : 0);
            else
                send_sample(rand_pos(cfg_map_w), rand_pos(cfg_map_h));
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready bursts, one long hold-off when requested.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                out_ready = 1'b0;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(noise_value);
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        func = FUNC_LOAD;
        table_index = '0;
        grad_x = '0;
        grad_y = '0;
        pos_x = '0;
        pos_y = '0;
        out_ready = 1'b0;
        items_done = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        hold_cnt = 0;
        stall_left = 0;
        cycle_count = 0;
        cfg_map_w = 13'd256;
        cfg_map_h = 13'd256;
        cfg_cells_x = 7'd4;
        cfg_cells_y = 7'd4;
        cfg_octaves = 4'd4;
        cfg_wrap = 2'd1;
        cfg_decay = 16'd8192;
        cfg_norm = 16'd8738;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset defaults: gradient extremes at the
        // table ends, then points at the map corners and past its far edge.
        send_item(FUNC_LOAD, 14'd0, -16'sd16384, 16'sd16384, 12'd0, 12'd0);
        send_item(FUNC_LOAD, 14'd16383, 16'sd16384, -16'sd16384, 12'd4095, 12'd4095);
        send_item(FUNC_LOAD, 14'd1, 16'sd0, 16'sd0, 12'd0, 12'd0);
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd255, 12'd255);
        send_sample(12'd128, 12'd64);
        drain();

        // Register extremes: a 4096-unit map with 64 cells per axis at one octave
        // and both axes wrapping, then a one-unit map, then zero extents and zero
        // cells with an octave count above eight, then no octaves at all, then the
        // widest lattice at eight octaves.
        set_config(4096, 4096, 64, 64, 1, 3, 65535, 65535);
        run_phase(80);
        set_config(1, 1, 1, 1, 2, 0, 0, 0);
        run_phase(40);
        set_config(0, 0, 0, 0, 15, 2, 16384, 16384);
        run_phase(15);
        set_config(300, 200, 5, 3, 0, 1, 8192, 8738);
        run_phase(20);
        set_config(8191, 8191, 127, 127, 8, 3, 20000, 4000);
        run_phase(40);

        // Random settings; most phases keep the octave count low so the run
        // stays short, and small maps push points beyond the map edge.
        while (items_done < TOTAL_ITEMS)
        begin
            set_config(($urandom_range(0, 3) == 0) ? $urandom_range(1, 300)
                                                   : $urandom_range(1, 4096),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300)
                                                   : $urandom_range(1, 4096),
                       $urandom_range(1, 64), $urandom_range(1, 64),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8)
                                                   : $urandom_range(1, 3),
                       $urandom_range(0, 3),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(4096, 24576),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(2000, 20000));
            run_phase(150);
        end

        if (sb.clean())
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
